### sv/iuls_pkg.sv
// shared constants, codes and types of the io unit latency scheduler
package iuls_pkg;

   localparam int MAX_UNITS   = 16;
   localparam int BLOCK_SHIFT = 9;

   // unit address and unit count widths
   localparam int UNIT_AW    = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
   localparam int UNIT_CNT_W = $clog2(MAX_UNITS + 1);

   // serial remainder unit: bits of the dividend handled per cycle
   localparam int MOD_DIV_W  = 64;
   localparam int MOD_DIGIT  = 4;
   localparam int MOD_STEPS  = MOD_DIV_W / MOD_DIGIT;
   localparam int MOD_CW     = $clog2(MOD_STEPS);
   localparam int MOD_RW     = UNIT_CNT_W + 1;

   // operation codes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;
   localparam logic [1:0] OP_EDGE  = 2'd3;

   // register indexes
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_SIZE_SHIFT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_COUNT      = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_SETUP      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_CHUNK      = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_TAIL       = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_SETUP     = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_CHUNK     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_TAIL      = 4'd7;

   // busy table access
   typedef struct packed {
      logic               rd_en;
      logic [UNIT_AW-1:0] rd_addr;
      logic               wr_en;
      logic [UNIT_AW-1:0] wr_addr;
      logic [63:0]        wr_data;
   } tbl_req_type;

   // remainder unit launch
   typedef struct packed {
      logic                  start;
      logic [MOD_DIV_W-1:0]  dividend;
      logic [UNIT_CNT_W-1:0] divisor;
   } mod_req_type;

endpackage

### sv/iuls_if.sv
// channel interfaces of the io unit latency scheduler
interface iuls_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [63:0] start_lba;
   logic [15:0] block_count_minus_one;
   logic [31:0] edge_bytes;
   logic [63:0] now_ns;

   modport source (
      output valid, operation, start_lba, block_count_minus_one, edge_bytes, now_ns,
      input  ready
   );
   modport sink (
      input  valid, operation, start_lba, block_count_minus_one, edge_bytes, now_ns,
      output ready
   );
endinterface

interface iuls_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] completion_ns;

   modport source (output valid, completion_ns, input ready);
   modport sink (input valid, completion_ns, output ready);
endinterface

interface iuls_csr_if;
   logic                           valid;
   logic                           ready;
   logic [iuls_pkg::CSR_IDX_W-1:0] reg_index;
   logic [31:0]                    wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

### sv/iuls_table.sv
// busy-until table: synchronous memory with per-entry valid bits
module iuls_table (
   input  logic                  clock,
   input  logic                  reset,
   input  iuls_pkg::tbl_req_type req,
   output logic [63:0]           rd_data
);

   logic [63:0]                   mem [iuls_pkg::MAX_UNITS];
   logic [iuls_pkg::MAX_UNITS-1:0] valid_ff;
   logic [63:0]                   rd_data_ff;
   logic                          rd_valid_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            valid_ff[req.wr_addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_valid_ff <= valid_ff[req.rd_addr];
         end
      end
   end

   // never-written entries read as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : 64'd0;

endmodule

### sv/iuls_mod.sv
// serial remainder by the unit count, a few dividend bits per cycle
module iuls_mod (
   input  logic                           clock,
   input  logic                           reset,
   input  iuls_pkg::mod_req_type          req,
   output logic                           done,
   output logic [iuls_pkg::UNIT_AW-1:0]   rem
);

   logic [iuls_pkg::MOD_DIV_W-1:0]  shreg_ff;
   logic [iuls_pkg::MOD_RW-1:0]     rem_ff;
   logic [iuls_pkg::MOD_RW-1:0]     rem_in;
   logic [iuls_pkg::UNIT_CNT_W-1:0] div_ff;
   logic [iuls_pkg::MOD_CW-1:0]     cnt_ff;
   logic                            busy_ff;
   logic                            done_ff;

   always_comb begin
      logic [iuls_pkg::MOD_RW-1:0] r;
      r = rem_ff;
      for (int i = 0; i < iuls_pkg::MOD_DIGIT; i++) begin
         r = {r[iuls_pkg::MOD_RW-2:0], shreg_ff[iuls_pkg::MOD_DIV_W-1-i]};
         if (r >= iuls_pkg::MOD_RW'(div_ff)) begin
            r = r - iuls_pkg::MOD_RW'(div_ff);
         end
      end
      rem_in = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff  <= 1'b1;
            cnt_ff   <= '0;
            shreg_ff <= req.dividend;
            rem_ff   <= '0;
            div_ff   <= req.divisor;
         end else if (busy_ff) begin
            rem_ff   <= rem_in;
            shreg_ff <= shreg_ff << iuls_pkg::MOD_DIGIT;
            cnt_ff   <= cnt_ff + iuls_pkg::MOD_CW'(1);
            if (cnt_ff == iuls_pkg::MOD_CW'(iuls_pkg::MOD_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign rem  = iuls_pkg::UNIT_AW'(rem_ff);

endmodule

### sv/io_unit_latency_scheduler.sv
// top level of the io unit latency scheduler
//
// Completion-time model for parallel I/O units of a storage device. Each
// request transaction on req_chan (read, write, flush or edge command)
// returns one transaction on rsp_chan carrying completion_ns. Registers are
// written through csr_chan, which is always ready; write them only while
// the block is idle.
//
// One request is worked on at a time. A read or write passes through the
// serial remainder unit twice (for the start unit, then for the chunk count),
// followed by one busy table write per visited unit, min(units, chunks) of
// them; an edge command skips the table writes, and a flush reads the table
// one unit a cycle.
//
// Reset clears the registers to their defaults and marks every table entry
// as zero. The response sits in an output register: a new request is taken
// while it waits, and a finished result holds back until rsp_chan drains.
module io_unit_latency_scheduler (
   input logic         clock,
   input logic         reset,
   iuls_req_if.sink    req_chan,
   iuls_rsp_if.source  rsp_chan,
   iuls_csr_if.sink    csr_chan
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_PREP    = 3'd1;
   localparam logic [2:0] ST_MOD_LBA = 3'd2;
   localparam logic [2:0] ST_MOD_CNT = 3'd3;
   localparam logic [2:0] ST_SUM     = 3'd4;
   localparam logic [2:0] ST_WALK    = 3'd5;
   localparam logic [2:0] ST_FLUSH   = 3'd6;
   localparam logic [2:0] ST_DONE    = 3'd7;

   localparam int AW = iuls_pkg::UNIT_AW;
   localparam int CW = iuls_pkg::UNIT_CNT_W;
   localparam int PW = AW + 32;

   // registers
   logic [4:0]  usz_shift_ff;
   logic [4:0]  ucount_ff;
   logic [31:0] r_setup_ff, r_chunk_ff, r_tail_ff;
   logic [31:0] w_setup_ff, w_chunk_ff, w_tail_ff;

   logic [2:0]    state_ff;
   logic [1:0]    op_ff;
   logic [63:0]   lba_ff;
   logic [15:0]   bm1_ff;
   logic [31:0]   edge_ff;
   logic [63:0]   now_ff;
   logic [31:0]   chunks_ff;
   logic [63:0]   prod_ff;
   logic [63:0]   base_ff;
   logic [63:0]   res_ff;
   logic [AW-1:0] start_ff;
   logic [AW-1:0] unit_ff;
   logic [AW-1:0] d_ff;
   logic [CW-1:0] k_ff;
   logic          pend_ff;
   logic          rsp_valid_ff;
   logic [63:0]   rsp_data_ff;

   // datapath
   logic [CW-1:0] n_units;
   logic [31:0]   sel_setup, sel_lat, sel_tail;
   logic [31:0]   bytes;
   logic [32:0]   chunk_sum;
   logic [31:0]   chunk_raw;
   logic [63:0]   lba_sh;
   logic [PW-1:0] d_prod;
   logic          tail_hit;
   logic [63:0]   walk_t;
   logic          walk_last;
   logic          flush_rd;
   logic          rsp_load;

   iuls_pkg::tbl_req_type tbl_req;
   iuls_pkg::mod_req_type mod_req;
   logic [63:0]           tbl_rd_data;
   logic                  mod_done;
   logic [AW-1:0]         mod_rem;

   iuls_table u_table (
      .clock   (clock),
      .reset   (reset),
      .req     (tbl_req),
      .rd_data (tbl_rd_data)
   );

   iuls_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   always_comb begin
      if (ucount_ff == 5'd0) begin
         n_units = CW'(1);
      end else if (ucount_ff > 5'(iuls_pkg::MAX_UNITS)) begin
         n_units = CW'(iuls_pkg::MAX_UNITS);
      end else begin
         n_units = CW'(ucount_ff);
      end
   end

   always_comb begin
      if (op_ff == iuls_pkg::OP_WRITE) begin
         sel_setup = w_setup_ff;
         sel_lat   = w_chunk_ff;
         sel_tail  = w_tail_ff;
      end else begin
         sel_setup = r_setup_ff;
         sel_lat   = r_chunk_ff;
         sel_tail  = r_tail_ff;
      end
   end

   assign bytes = (op_ff == iuls_pkg::OP_EDGE) ? edge_ff :
                  ((32'(bm1_ff) + 32'd1) << iuls_pkg::BLOCK_SHIFT);
   assign chunk_sum = 33'(bytes) + (33'd1 << usz_shift_ff) - 33'd1;
   assign chunk_raw = 32'(chunk_sum >> usz_shift_ff);

   assign lba_sh = (usz_shift_ff > 5'(iuls_pkg::BLOCK_SHIFT)) ?
                   (lba_ff >> (usz_shift_ff - 5'(iuls_pkg::BLOCK_SHIFT))) : lba_ff;

   // unit k holds chunk number chunks - d, d counting down from (chunks-1) mod n
   assign d_prod    = PW'(d_ff) * PW'(sel_lat);
   assign tail_hit  = (chunks_ff - 32'(d_ff)) <= 32'(n_units);
   assign walk_t    = res_ff - 64'(d_prod) + (tail_hit ? 64'(sel_tail) : 64'd0);
   assign walk_last = ((k_ff + CW'(1)) == n_units) ||
                      ((32'(k_ff) + 32'd1) == chunks_ff);
   assign flush_rd  = (state_ff == ST_FLUSH) && (k_ff < n_units);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      tbl_req         = '0;
      mod_req         = '0;
      mod_req.divisor = n_units;
      case (state_ff)
         ST_PREP: begin
            mod_req.start    = 1'b1;
            mod_req.dividend = lba_sh;
         end
         ST_MOD_LBA: begin
            tbl_req.rd_en    = mod_done;
            tbl_req.rd_addr  = mod_rem;
            mod_req.start    = mod_done;
            mod_req.dividend = 64'(chunks_ff - 32'd1);
         end
         ST_WALK: begin
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_addr = unit_ff;
            tbl_req.wr_data = walk_t;
         end
         ST_FLUSH: begin
            tbl_req.rd_en   = flush_rd;
            tbl_req.rd_addr = AW'(k_ff);
         end
         default: begin
         end
      endcase
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         usz_shift_ff <= 5'd12;
         ucount_ff    <= 5'd8;
         r_setup_ff   <= '0;
         r_chunk_ff   <= '0;
         r_tail_ff    <= '0;
         w_setup_ff   <= '0;
         w_chunk_ff   <= '0;
         w_tail_ff    <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            iuls_pkg::CSR_UNIT_SIZE_SHIFT: usz_shift_ff <= csr_chan.wdata[4:0];
            iuls_pkg::CSR_UNIT_COUNT:      ucount_ff    <= csr_chan.wdata[4:0];
            iuls_pkg::CSR_READ_SETUP:      r_setup_ff   <= csr_chan.wdata;
            iuls_pkg::CSR_READ_CHUNK:      r_chunk_ff   <= csr_chan.wdata;
            iuls_pkg::CSR_READ_TAIL:       r_tail_ff    <= csr_chan.wdata;
            iuls_pkg::CSR_WRITE_SETUP:     w_setup_ff   <= csr_chan.wdata;
            iuls_pkg::CSR_WRITE_CHUNK:     w_chunk_ff   <= csr_chan.wdata;
            iuls_pkg::CSR_WRITE_TAIL:      w_tail_ff    <= csr_chan.wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         k_ff         <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  op_ff   <= req_chan.operation;
                  lba_ff  <= req_chan.start_lba;
                  bm1_ff  <= req_chan.block_count_minus_one;
                  edge_ff <= req_chan.edge_bytes;
                  now_ff  <= req_chan.now_ns;
                  res_ff  <= '0;
                  k_ff    <= '0;
                  pend_ff <= 1'b0;
                  state_ff <= (req_chan.operation == iuls_pkg::OP_FLUSH) ?
                              ST_FLUSH : ST_PREP;
               end
            end
            ST_PREP: begin
               chunks_ff <= (chunk_raw == 32'd0) ? 32'd1 : chunk_raw;
               state_ff  <= ST_MOD_LBA;
            end
            ST_MOD_LBA: begin
               prod_ff <= 64'(chunks_ff) * 64'(sel_lat);
               if (mod_done) begin
                  start_ff <= mod_rem;
                  state_ff <= ST_MOD_CNT;
               end
            end
            ST_MOD_CNT: begin
               // start unit's busy time is on the table output from the first cycle
               base_ff <= ((now_ff > tbl_rd_data) ? now_ff : tbl_rd_data) +
                          64'(sel_setup);
               if (mod_done) begin
                  d_ff     <= mod_rem;
                  unit_ff  <= start_ff;
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               res_ff   <= base_ff + prod_ff;
               k_ff     <= '0;
               state_ff <= (op_ff == iuls_pkg::OP_EDGE) ? ST_DONE : ST_WALK;
            end
            ST_WALK: begin
               k_ff    <= k_ff + CW'(1);
               unit_ff <= ((CW'(unit_ff) + CW'(1)) == n_units) ? '0 : unit_ff + AW'(1);
               d_ff    <= (d_ff == '0) ? AW'(n_units - CW'(1)) : d_ff - AW'(1);
               if (walk_last) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_FLUSH: begin
               pend_ff <= flush_rd;
               if (flush_rd) begin
                  k_ff <= k_ff + CW'(1);
               end
               if (pend_ff && (tbl_rd_data > res_ff)) begin
                  res_ff <= tbl_rd_data;
               end
               if (!flush_rd && !pend_ff) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_data_ff <= res_ff;
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.completion_ns = rsp_data_ff;
   assign csr_chan.ready         = 1'b1;

endmodule

### sim/io_unit_latency_scheduler_test.sv
// self-checking testbench of the io unit latency scheduler: directed table, then random traffic
module io_unit_latency_scheduler_test;
   import iuls_pkg::*;

   localparam int NUM_REGS    = CSR_WRITE_TAIL + 1;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE      = 60;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 4'd8;

   typedef logic [31:0] reg_set_t [NUM_REGS];

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] start_lba;
      logic [15:0] block_count_minus_one;
      logic [31:0] edge_bytes;
      logic [63:0] now_ns;
   } request_t;

   typedef enum {ROW_REQUEST, ROW_SETUP} plan_kind_e;

   typedef struct {
      plan_kind_e  kind;
      request_t    req;
      int          setup_sel;
      bit          typed;
      logic [63:0] completion;
   } plan_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   iuls_req_if req_bus ();
   iuls_rsp_if rsp_bus ();
   iuls_csr_if csr_bus ();

   io_unit_latency_scheduler u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: register shadow and per-unit busy-until times
   logic [31:0] timing_regs [2**CSR_IDX_W];
   logic [63:0] unit_free_ns [MAX_UNITS];
   logic [63:0] completions_due [$];

   int          mismatch_count = 0;
   int          stall_cycles = 0;
   int          send_idle_pct = 0;
   int          rsp_idle_pct = 0;
   bit          note_typed = 1'b0;
   logic [63:0] note_completion = '0;
   logic [63:0] sim_now = '0;

   plan_row_t   directed_plan [$];
   reg_set_t    directed_setups [4];

   initial begin
      foreach (timing_regs[i]) timing_regs[i] = '0;
      timing_regs[CSR_UNIT_SIZE_SHIFT] = 32'd12;
      timing_regs[CSR_UNIT_COUNT]      = 32'd8;
      foreach (unit_free_ns[i]) unit_free_ns[i] = '0;
   end

   function automatic logic [63:0] schedule_request(input request_t r);
      logic [63:0] n, sh, bytes, chunks, base, setup, lat, tail, start, last, t, latest, k;
      n = 64'(timing_regs[CSR_UNIT_COUNT][4:0]);
      if (n == 0) begin
         n = 1;
      end else if (n > MAX_UNITS) begin
         n = MAX_UNITS;
      end
      sh = 64'(timing_regs[CSR_UNIT_SIZE_SHIFT][4:0]);

      if (r.operation == OP_FLUSH) begin
         latest = '0;
         for (k = 0; k < n; k++)
            if (unit_free_ns[k] > latest) latest = unit_free_ns[k];
         return latest;
      end

      if (r.operation == OP_WRITE) begin
         setup = 64'(timing_regs[CSR_WRITE_SETUP]);
         lat   = 64'(timing_regs[CSR_WRITE_CHUNK]);
         tail  = 64'(timing_regs[CSR_WRITE_TAIL]);
      end else begin
         setup = 64'(timing_regs[CSR_READ_SETUP]);
         lat   = 64'(timing_regs[CSR_READ_CHUNK]);
         tail  = 64'(timing_regs[CSR_READ_TAIL]);
      end

      if (r.operation == OP_EDGE)
         bytes = 64'(r.edge_bytes);
      else
         bytes = (64'(r.block_count_minus_one) + 64'd1) << BLOCK_SHIFT;

      chunks = (bytes + (64'd1 << sh) - 64'd1) >> sh;
      if (chunks == 0) chunks = 1;

      // chunks no larger than a block pick the unit from the raw lba
      if (sh > BLOCK_SHIFT)
         start = (r.start_lba >> (sh - BLOCK_SHIFT)) % n;
      else
         start = r.start_lba % n;

      base = unit_free_ns[start];
      if (r.now_ns > base) base = r.now_ns;
      base = base + setup;

      if (r.operation != OP_EDGE) begin
         // each unit keeps the finish time of the last chunk placed on it
         for (k = 0; k < n && k < chunks; k++) begin
            last = k + n * ((chunks - 64'd1 - k) / n);
            t = base + (last + 64'd1) * lat;
            if (last < n) t = t + tail;
            unit_free_ns[(start + k) % n] = t;
         end
      end
      return base + chunks * lat;
   endfunction

   always @(posedge clock) begin : monitor
      request_t    seen;
      logic [63:0] want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (completions_due.size() == 0) begin
               $error("completion_ns: expected none, actual %h", rsp_bus.completion_ns);
               mismatch_count++;
            end else begin
               want = completions_due.pop_front();
               if (rsp_bus.completion_ns !== want) begin
                  $error("completion_ns: expected %h, actual %h", want, rsp_bus.completion_ns);
                  mismatch_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.operation             = req_bus.operation;
            seen.start_lba             = req_bus.start_lba;
            seen.block_count_minus_one = req_bus.block_count_minus_one;
            seen.edge_bytes            = req_bus.edge_bytes;
            seen.now_ns                = req_bus.now_ns;
            want = schedule_request(seen);
            completions_due.push_back(note_typed ? note_completion : want);
         end
         if (csr_bus.valid && csr_bus.ready)
            timing_regs[csr_bus.reg_index] = csr_bus.wdata;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   task automatic wait_drained();
      while (completions_due.size() != 0) @(negedge clock);
   endtask

   task automatic drive_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wdata     <= data;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
   endtask

   // registers change only with no transaction in flight
   task automatic load_config(input reg_set_t r);
      req_bus.valid <= 1'b0;
      wait_drained();
      for (int i = 0; i < NUM_REGS; i++)
         drive_csr(CSR_IDX_W'(i), r[i]);
      drive_csr(CSR_UNMAPPED, $urandom);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_request(input request_t r, input bit typed, input logic [63:0] completion);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid                 <= 1'b1;
      req_bus.operation             <= r.operation;
      req_bus.start_lba             <= r.start_lba;
      req_bus.block_count_minus_one <= r.block_count_minus_one;
      req_bus.edge_bytes            <= r.edge_bytes;
      req_bus.now_ns                <= r.now_ns;
      note_typed      = typed;
      note_completion = completion;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_delay();
      case ($urandom_range(9))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return $urandom;
         default: return $urandom_range(1000);
      endcase
   endfunction

   task automatic pick_random_setup(output reg_set_t r);
      logic [4:0] sh, cnt;
      sh  = ($urandom_range(99) < 80) ? 5'($urandom_range(24, 9)) : 5'($urandom_range(31));
      cnt = ($urandom_range(99) < 75) ? 5'($urandom_range(16, 1)) : 5'($urandom_range(31));
      // upper bits are don't-care for the 5-bit registers
      r[CSR_UNIT_SIZE_SHIFT] = {27'($urandom), sh};
      r[CSR_UNIT_COUNT]      = {27'($urandom), cnt};
      r[CSR_READ_SETUP]      = random_delay();
      r[CSR_READ_CHUNK]      = random_delay();
      r[CSR_READ_TAIL]       = random_delay();
      r[CSR_WRITE_SETUP]     = random_delay();
      r[CSR_WRITE_CHUNK]     = random_delay();
      r[CSR_WRITE_TAIL]      = random_delay();
   endtask

   function automatic request_t random_request();
      request_t r;
      case ($urandom_range(3))
         0:       r.operation = OP_READ;
         1:       r.operation = OP_WRITE;
         2:       r.operation = OP_FLUSH;
         default: r.operation = OP_EDGE;
      endcase
      r.start_lba = ($urandom_range(99) < 40) ? {$urandom, $urandom}
                                              : 64'($urandom_range(1 << 20));
      case ($urandom_range(9))
         0:       r.block_count_minus_one = 16'($urandom);
         1, 2:    r.block_count_minus_one = 16'($urandom_range(2047));
         default: r.block_count_minus_one = 16'($urandom_range(63));
      endcase
      case ($urandom_range(9))
         0:          r.edge_bytes = 32'd0;
         1:          r.edge_bytes = 32'hFFFF_FFFF;
         2, 3, 4, 5: r.edge_bytes = $urandom;
         default:    r.edge_bytes = $urandom_range(65535);
      endcase
      // mostly a rising clock so the busy table decides the start time
      if ($urandom_range(99) < 15) begin
         r.now_ns = {$urandom, $urandom};
      end else begin
         sim_now  = sim_now + 64'($urandom_range(500));
         r.now_ns = sim_now;
      end
      return r;
   endfunction

   function automatic plan_row_t req_row(input logic [1:0] op, input logic [63:0] lba,
                                         input logic [15:0] bcm, input logic [31:0] eb,
                                         input logic [63:0] now);
      plan_row_t row;
      row.kind                      = ROW_REQUEST;
      row.req.operation             = op;
      row.req.start_lba             = lba;
      row.req.block_count_minus_one = bcm;
      row.req.edge_bytes            = eb;
      row.req.now_ns                = now;
      row.setup_sel                 = 0;
      row.typed                     = 1'b0;
      row.completion                = '0;
      return row;
   endfunction

   function automatic plan_row_t typed_row(input logic [1:0] op, input logic [63:0] lba,
                                           input logic [15:0] bcm, input logic [31:0] eb,
                                           input logic [63:0] now, input logic [63:0] exp_ns);
      plan_row_t row;
      row            = req_row(op, lba, bcm, eb, now);
      row.typed      = 1'b1;
      row.completion = exp_ns;
      return row;
   endfunction

   function automatic plan_row_t setup_row(input int sel);
      plan_row_t row;
      row           = req_row(OP_READ, '0, '0, '0, '0);
      row.kind      = ROW_SETUP;
      row.setup_sel = sel;
      return row;
   endfunction

   initial begin
      reg_set_t setup;
      request_t r;

      req_bus.valid                 = 1'b0;
      req_bus.operation             = OP_READ;
      req_bus.start_lba             = '0;
      req_bus.block_count_minus_one = '0;
      req_bus.edge_bytes            = '0;
      req_bus.now_ns                = '0;
      rsp_bus.ready                 = 1'b0;
      csr_bus.valid                 = 1'b0;
      csr_bus.reg_index             = CSR_UNIT_SIZE_SHIFT;
      csr_bus.wdata                 = '0;

      // order: shift, count, read setup/chunk/tail, write setup/chunk/tail
      directed_setups[0] = '{32'd9, 32'd16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'd0, 32'd1, 32'd7};
      directed_setups[1] = '{32'd0, 32'd0, 32'd10, 32'd3, 32'd5, 32'd20, 32'd4, 32'd6};
      directed_setups[2] = '{32'd31, 32'd31, 32'd1, 32'd2, 32'd3,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      directed_setups[3] = '{32'd10, 32'd3, 32'd0, 32'd100, 32'd50, 32'd5, 32'd7, 32'd11};

      // reset defaults: all delays zero, so a read, write or edge completes at its arrival time
      directed_plan.push_back(typed_row(OP_FLUSH, '0, '0, '0, '0, 64'd0));
      directed_plan.push_back(typed_row(OP_READ, '0, '0, '0, '0, 64'd0));
      directed_plan.push_back(typed_row(OP_WRITE, '0, '0, '0, 64'd100, 64'd100));
      directed_plan.push_back(typed_row(OP_EDGE, '1, '0, 32'd0, 64'd50, 64'd50));
      directed_plan.push_back(typed_row(OP_FLUSH, '0, '0, '0, '0, 64'd100));
      // extreme read delays, small write delays, sixteen units, one block per chunk
      directed_plan.push_back(setup_row(0));
      directed_plan.push_back(req_row(OP_READ, '1, '1, '0, '1));
      directed_plan.push_back(req_row(OP_WRITE, '1, '1, '0, '0));
      directed_plan.push_back(req_row(OP_EDGE, '0, '0, 32'hFFFF_FFFF, 64'd1000));
      directed_plan.push_back(req_row(OP_EDGE, 64'd5, '0, 32'd0, 64'd2000));
      directed_plan.push_back(req_row(OP_FLUSH, '0, '0, '0, '0));
      // zero unit count, chunk below one block
      directed_plan.push_back(setup_row(1));
      directed_plan.push_back(req_row(OP_READ, 64'd123456789, 16'd3, '0, 64'd10));
      directed_plan.push_back(req_row(OP_WRITE, '1, '0, '0, '0));
      directed_plan.push_back(req_row(OP_EDGE, 64'd7, '0, 32'd1, 64'd5));
      directed_plan.push_back(req_row(OP_FLUSH, '0, '0, '0, '0));
      // unit count above the maximum, huge chunks, top units written
      directed_plan.push_back(setup_row(2));
      directed_plan.push_back(req_row(OP_WRITE, 64'hF << 22, 16'hFFFF, '0, 64'd3000));
      directed_plan.push_back(req_row(OP_READ, 64'h7 << 22, 16'd100, '0, 64'd4000));
      directed_plan.push_back(req_row(OP_WRITE, '0, '0, '0, '1));
      directed_plan.push_back(req_row(OP_FLUSH, '0, '0, '0, '0));
      // three units: flush ignores the upper entries, chunks wrap over units
      directed_plan.push_back(setup_row(3));
      directed_plan.push_back(req_row(OP_FLUSH, '0, '0, '0, '0));
      directed_plan.push_back(req_row(OP_WRITE, 64'd5, 16'd100, '0, 64'd10000));
      directed_plan.push_back(req_row(OP_READ, 64'd1, 16'd6, '0, 64'd0));
      directed_plan.push_back(req_row(OP_EDGE, 64'd4, '0, 32'd3000, 64'd20000));
      directed_plan.push_back(req_row(OP_FLUSH, '0, '0, '0, '0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 34;
      rsp_idle_pct  = 83;
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_SETUP)
            load_config(directed_setups[directed_plan[i].setup_sel]);
         else
            send_request(directed_plan[i].req, directed_plan[i].typed,
                         directed_plan[i].completion);
      end

      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            send_idle_pct = 83;
            rsp_idle_pct  = 34;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         pick_random_setup(setup);
         load_config(setup);
         repeat (88) begin
            r = random_request();
            send_request(r, 1'b0, '0);
         end
      end

      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (SETTLE) @(negedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
